// ----- hw/rtl/cfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the checksummed frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int unsigned MAX_LEN_DEFAULT  = 20;
    localparam logic [15:0] LIMIT_RESET      = 16'd1000;

    localparam logic [7:0]  HDR_START        = 8'hAA;
    localparam logic [7:0]  HDR_THIRD        = 8'h05;
    localparam logic [7:0]  HDR_FOURTH       = 8'h42;

    localparam int unsigned FUNC_BYTE        = 0;
    localparam int unsigned FUNC_TICK        = 1;

    // frame positions that feed the output fields
    localparam int unsigned NUM_CAP          = 9;
    localparam int unsigned CAP_POS [NUM_CAP] = '{5, 6, 7, 8, 9, 12, 13, 14, 15};

    typedef struct packed {
        logic               frame_ok;
        logic               checksum_bad;
        logic [7:0]         switch_value;
        logic [7:0]         status_byte;
        logic [7:0]         angle_byte;
        logic [7:0]         go_byte;
        logic [7:0]         turn_byte;
        logic signed [15:0] position_x;
        logic signed [15:0] position_y;
        logic               offline;
        logic               target_valid;
    } t_result;

endpackage

// ----- hw/rtl/cfr_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_parser
// Frame parser, running checksum, field capture and silence timer.
// Updates its state on each enabled item and presents that item's result.
// ----------------------------------------------------------------------------
module cfr_parser
    import cfr_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_func,
    input  logic [7:0]  i_value,
    input  logic [15:0] i_limit,
    output t_result     o_result
);

    localparam int unsigned PW = $clog2(MAX_LEN + 5);
    localparam int unsigned LW = $clog2(MAX_LEN);

    logic [PW-1:0] r_pos,    n_pos;
    logic [LW-1:0] r_len,    n_len;
    logic [7:0]    r_sum,    n_sum;
    logic [7:0]    r_store   [NUM_CAP];
    logic [7:0]    n_store   [NUM_CAP];
    logic [7:0]    r_cap     [NUM_CAP];
    logic [7:0]    n_cap     [NUM_CAP];
    logic [15:0]   r_timer,  n_timer;
    logic          r_offline, n_offline;
    logic          r_tvalid,  n_tvalid;
    logic          w_ok, w_bad;
    logic [PW-1:0] w_last;
    logic [16:0]   w_tsum;

    assign w_last = PW'(r_len) + PW'(5);
    assign w_tsum = {1'b0, r_timer} + {9'd0, i_value};

    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_sum     = r_sum;
        n_timer   = r_timer;
        n_offline = r_offline;
        n_tvalid  = r_tvalid;
        w_ok      = 1'b0;
        w_bad     = 1'b0;
        for (int k = 0; k < NUM_CAP; k++) begin
            n_store[k] = r_store[k];
            n_cap[k]   = r_cap[k];
        end
        if (i_en) begin
            if (i_func == 1'(FUNC_TICK)) begin
                if (r_timer < i_limit) begin
                    n_timer = w_tsum[16] ? 16'hFFFF : w_tsum[15:0];
                end else begin
                    n_offline = 1'b1;
                    n_tvalid  = 1'b0;
                end
            end else begin
                for (int k = 0; k < NUM_CAP; k++) begin
                    if (r_pos == PW'(CAP_POS[k])) begin
                        n_store[k] = i_value;
                    end
                end
                if (r_pos == PW'(0)) begin
                    n_sum = i_value;
                    n_pos = (i_value == HDR_START) ? PW'(1) : PW'(0);
                end else if (r_pos == PW'(1)) begin
                    n_sum = r_sum + i_value;
                    n_pos = PW'(2);
                end else if (r_pos == PW'(2)) begin
                    n_sum = r_sum + i_value;
                    n_pos = (i_value == HDR_THIRD) ? PW'(3) : PW'(0);
                end else if (r_pos == PW'(3)) begin
                    n_sum = r_sum + i_value;
                    n_pos = (i_value == HDR_FOURTH) ? PW'(4) : PW'(0);
                end else if (r_pos == PW'(4)) begin
                    n_sum = r_sum + i_value;
                    if (i_value < 8'(MAX_LEN)) begin
                        n_len = LW'(i_value);
                        n_pos = PW'(5);
                    end else begin
                        n_pos = PW'(0);
                    end
                end else if (r_pos == w_last) begin
                    if (r_sum == i_value) begin
                        w_ok      = 1'b1;
                        n_timer   = 16'd0;
                        n_offline = 1'b0;
                        n_tvalid  = 1'b1;
                        for (int k = 0; k < NUM_CAP; k++) begin
                            n_cap[k] = n_store[k];
                        end
                    end else begin
                        w_bad = 1'b1;
                    end
                    n_pos = PW'(0);
                end else if (r_pos < w_last) begin
                    n_sum = r_sum + i_value;
                    n_pos = r_pos + PW'(1);
                end else begin
                    n_pos = PW'(0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len     <= '0;
            r_sum     <= '0;
            r_timer   <= '0;
            r_offline <= 1'b0;
            r_tvalid  <= 1'b0;
            for (int k = 0; k < NUM_CAP; k++) begin
                r_store[k] <= '0;
                r_cap[k]   <= '0;
            end
        end else begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_sum     <= n_sum;
            r_timer   <= n_timer;
            r_offline <= n_offline;
            r_tvalid  <= n_tvalid;
            for (int k = 0; k < NUM_CAP; k++) begin
                r_store[k] <= n_store[k];
                r_cap[k]   <= n_cap[k];
            end
        end
    end

    always_comb begin
        o_result.frame_ok     = w_ok;
        o_result.checksum_bad = w_bad;
        o_result.switch_value = n_cap[0];
        o_result.status_byte  = n_cap[1];
        o_result.angle_byte   = n_cap[2];
        o_result.go_byte      = n_cap[3];
        o_result.turn_byte    = n_cap[4];
        o_result.position_x   = signed'({n_cap[5], n_cap[6]});
        o_result.position_y   = signed'({n_cap[7], n_cap[8]});
        o_result.offline      = n_offline;
        o_result.target_valid = n_tvalid;
    end

endmodule

// ----- hw/rtl/cfr_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_out_buf
// Two-entry result buffer; takes a new result while one waits downstream.
// ----------------------------------------------------------------------------
module cfr_out_buf
    import cfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_can_push,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       w_push, w_pop;

    assign o_can_push = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_data     = r_mem[r_rd_ptr];
    assign w_push     = i_push && o_can_push;
    assign w_pop      = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ w_pop;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- hw/rtl/checksummed_frame_receiver_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_top
// Byte-stream frame receiver with 8-bit sum checksum and offline timer.
//
// Input channel (i_valid/o_ready): one item is either a received byte
// (i_func = 0) or a time tick carrying elapsed milliseconds (i_func = 1).
// Output channel (o_valid/i_ready): exactly one result item per input item,
// in order, with the capture fields and flags as they stand after that item.
// Config: i_cfg_wr_en/i_cfg_wr_data load the offline limit.
//
// Path: an accepted item enters the input register, is parsed there and
// is written into the result buffer when it has room; o_valid is then high.
// Throughput: one item per cycle while the result buffer has room.
// The two-entry result buffer lets the input keep flowing while one result
// waits; when the receiver stalls long enough, the buffer and input register
// fill and o_ready drops until results are taken.
// Reset clears parser state, frame store, captured fields, timer, flags and
// all pipeline valids; the limit returns to 1000 ms.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver_top
    import cfr_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [7:0]         i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_frame_ok,
    output logic               o_checksum_bad,
    output logic [7:0]         o_switch_value,
    output logic [7:0]         o_status_byte,
    output logic [7:0]         o_angle_byte,
    output logic [7:0]         o_go_byte,
    output logic [7:0]         o_turn_byte,
    output logic signed [15:0] o_position_x,
    output logic signed [15:0] o_position_y,
    output logic               o_offline,
    output logic               o_target_valid
);

    logic        r_in_vld;
    logic        r_in_func;
    logic [7:0]  r_in_value;
    logic [15:0] r_limit;
    logic        w_adv;
    logic        w_can_push;
    t_result     w_res;
    t_result     w_out;

    assign w_adv   = r_in_vld && w_can_push;
    assign o_ready = !r_in_vld || w_can_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_limit  <= LIMIT_RESET;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_func  <= i_func;
            r_in_value <= i_value;
        end
    end

    cfr_parser #(
        .MAX_LEN (MAX_LEN)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_func   (r_in_func),
        .i_value  (r_in_value),
        .i_limit  (r_limit),
        .o_result (w_res)
    );

    cfr_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (r_in_vld),
        .i_data     (w_res),
        .o_can_push (w_can_push),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (w_out)
    );

    assign o_frame_ok     = w_out.frame_ok;
    assign o_checksum_bad = w_out.checksum_bad;
    assign o_switch_value = w_out.switch_value;
    assign o_status_byte  = w_out.status_byte;
    assign o_angle_byte   = w_out.angle_byte;
    assign o_go_byte      = w_out.go_byte;
    assign o_turn_byte    = w_out.turn_byte;
    assign o_position_x   = w_out.position_x;
    assign o_position_y   = w_out.position_y;
    assign o_offline      = w_out.offline;
    assign o_target_valid = w_out.target_valid;

endmodule

// ----- hw/rtl/cfr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module cfr_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic               i_func,
    input  logic [7:0]         i_value,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic               o_frame_ok,
    input  logic               o_checksum_bad,
    input  logic [7:0]         o_switch_value,
    input  logic [7:0]         o_status_byte,
    input  logic [7:0]         o_angle_byte,
    input  logic [7:0]         o_go_byte,
    input  logic [7:0]         o_turn_byte,
    input  logic signed [15:0] o_position_x,
    input  logic signed [15:0] o_position_y,
    input  logic               o_offline,
    input  logic               o_target_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_ok) && $stable(o_position_x)
            && $stable(o_offline) && $stable(o_target_valid))
        else $error("result item changed while stalled");

    a_ok_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_frame_ok && o_checksum_bad))
        else $error("frame_ok and checksum_bad both set");

    a_ok_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_ok |-> o_target_valid && !o_offline)
        else $error("good frame without target valid");

    a_off_tv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_offline |-> !o_target_valid)
        else $error("target valid while offline");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind checksummed_frame_receiver_top cfr_checker u_cfr_checker (.*);

// ----- tb/sv/tb_checksummed_frame_receiver_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checksummed_frame_receiver_top
// Self-checking testbench for the checksummed frame receiver.
//
// Drives bytes and time ticks over the valid/ready input, predicts the
// parser, frame store, captured fields and offline timer for every accepted
// item, and checks each result item field by field in order. Covers header
// and length errors, bad checksums, short frames with stale fields, timer
// saturation, limit extremes, random frame traffic with random gaps on both
// sides, and a long receiver stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_checksummed_frame_receiver_top;
    import cfr_pkg::*;

    localparam int unsigned MAX_LEN     = MAX_LEN_DEFAULT;
    localparam int unsigned STORE_DEPTH = MAX_LEN + 5;
    localparam int unsigned FILL_RANDOM = 256;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned PHASE_ITEMS = 70;

    typedef enum int unsigned {
        FLAW_NONE   = 0,
        FLAW_SUM    = 1,
        FLAW_HEADER = 2,
        FLAW_LENGTH = 3,
        FLAW_CUT    = 4
    } t_frame_flaw;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_wr_en    = 1'b0;
    logic [15:0]        i_cfg_wr_data  = '0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic               i_func         = 1'b0;
    logic [7:0]         i_value        = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic               o_frame_ok;
    logic               o_checksum_bad;
    logic [7:0]         o_switch_value;
    logic [7:0]         o_status_byte;
    logic [7:0]         o_angle_byte;
    logic [7:0]         o_go_byte;
    logic [7:0]         o_turn_byte;
    logic signed [15:0] o_position_x;
    logic signed [15:0] o_position_y;
    logic               o_offline;
    logic               o_target_valid;

    checksummed_frame_receiver_top #(
        .MAX_LEN (MAX_LEN)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_ok     (o_frame_ok),
        .o_checksum_bad (o_checksum_bad),
        .o_switch_value (o_switch_value),
        .o_status_byte  (o_status_byte),
        .o_angle_byte   (o_angle_byte),
        .o_go_byte      (o_go_byte),
        .o_turn_byte    (o_turn_byte),
        .o_position_x   (o_position_x),
        .o_position_y   (o_position_y),
        .o_offline      (o_offline),
        .o_target_valid (o_target_valid)
    );

    // receiver-side view of the block
    int unsigned rx_pos;
    int unsigned rx_len;
    logic [7:0]  rx_sum;
    logic [7:0]  frame_mem [STORE_DEPTH];
    logic [7:0]  field_mem [NUM_CAP];
    logic [15:0] quiet_ms;
    logic [15:0] limit_ms;
    logic        offline_q;
    logic        target_q;

    t_result     pending_status [$];
    t_result     status_want;
    t_result     status_got;
    int unsigned mismatches  = 0;
    int unsigned items_sent  = 0;
    bit          tx_gaps     = 1'b1;
    bit          rx_gaps     = 1'b1;
    bit          tick_mix    = 1'b0;
    bit          hold_req    = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned rx_wait     = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void reset_receiver();
        rx_pos    = 0;
        rx_len    = 0;
        rx_sum    = '0;
        quiet_ms  = '0;
        limit_ms  = LIMIT_RESET;
        offline_q = 1'b0;
        target_q  = 1'b0;
        foreach (frame_mem[k]) frame_mem[k] = '0;
        foreach (field_mem[k]) field_mem[k] = '0;
    endfunction

    function automatic t_result next_frame_status(input bit tick, input logic [7:0] b);
        t_result     r;
        int unsigned p;
        int unsigned sum_ms;
        r = '0;
        if (tick) begin
            if (quiet_ms < limit_ms) begin
                sum_ms   = quiet_ms + b;
                quiet_ms = (sum_ms > 16'hFFFF) ? 16'hFFFF : sum_ms[15:0];
            end else begin
                offline_q = 1'b1;
                target_q  = 1'b0;
            end
        end else begin
            p = rx_pos;
            if (p < STORE_DEPTH) frame_mem[p] = b;
            if (p == 0) begin
                rx_sum = b;
                rx_pos = (b == HDR_START) ? 1 : 0;
            end else if (p == 1) begin
                rx_sum += b;
                rx_pos = 2;
            end else if (p == 2 || p == 3) begin
                rx_sum += b;
                rx_pos = (b == ((p == 2) ? HDR_THIRD : HDR_FOURTH)) ? p + 1 : 0;
            end else if (p == 4) begin
                rx_sum += b;
                if (b < MAX_LEN) begin
                    rx_len = b;
                    rx_pos = 5;
                end else begin
                    rx_pos = 0;
                end
            end else if (p == rx_len + 5) begin
                if (rx_sum == b) begin
                    r.frame_ok = 1'b1;
                    for (int k = 0; k < NUM_CAP; k++) field_mem[k] = frame_mem[CAP_POS[k]];
                    target_q  = 1'b1;
                    quiet_ms  = '0;
                    offline_q = 1'b0;
                end else begin
                    r.checksum_bad = 1'b1;
                end
                rx_pos = 0;
            end else if (p < rx_len + 5) begin
                rx_sum += b;
                rx_pos = p + 1;
            end else begin
                rx_pos = 0;
            end
        end
        r.switch_value = field_mem[0];
        r.status_byte  = field_mem[1];
        r.angle_byte   = field_mem[2];
        r.go_byte      = field_mem[3];
        r.turn_byte    = field_mem[4];
        r.position_x   = {field_mem[5], field_mem[6]};
        r.position_y   = {field_mem[7], field_mem[8]};
        r.offline      = offline_q;
        r.target_valid = target_q;
        return r;
    endfunction

    task automatic send_item(input int unsigned func, input logic [7:0] value);
        int unsigned gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= (func == FUNC_TICK);
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        pending_status.push_back(next_frame_status(func == FUNC_TICK, value));
        items_sent++;
    endtask

    // builds one frame, optionally damaged, and sends it byte by byte
    task automatic send_frame(input int unsigned len, input t_frame_flaw flaw,
                              input int unsigned fill);
        logic [7:0]  seq [$];
        logic [7:0]  sum;
        int unsigned idx;
        int unsigned cut;
        seq.push_back(HDR_START);
        seq.push_back((fill >= FILL_RANDOM) ? 8'($urandom) : 8'(fill));
        seq.push_back(HDR_THIRD);
        seq.push_back(HDR_FOURTH);
        if (flaw == FLAW_HEADER) begin
            idx = $urandom_range(0, 2);
            if (idx == 1) idx = 3;
            seq[idx] ^= 8'($urandom_range(1, 255));
        end
        seq.push_back((flaw == FLAW_LENGTH) ? 8'($urandom_range(MAX_LEN, 255)) : 8'(len));
        repeat (len) seq.push_back((fill >= FILL_RANDOM) ? 8'($urandom) : 8'(fill));
        sum = '0;
        foreach (seq[k]) sum += seq[k];
        if (flaw == FLAW_SUM) sum ^= 8'($urandom_range(1, 255));
        seq.push_back(sum);
        cut = (flaw == FLAW_CUT) ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (int k = 0; k < cut; k++) begin
            if (tick_mix && $urandom_range(0, 15) == 0) send_item(FUNC_TICK, 8'($urandom));
            send_item(FUNC_BYTE, seq[k]);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_status.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [15:0] ms);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= ms;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_ms = ms;
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        mismatches++;
    endtask

    // receiver: random stalls, plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (rx_wait != 0) begin
            i_ready <= 1'b0;
            rx_wait--;
        end else begin
            rx_wait = rx_gaps ? pick_gap() : 0;
            i_ready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            status_got.frame_ok     = o_frame_ok;
            status_got.checksum_bad = o_checksum_bad;
            status_got.switch_value = o_switch_value;
            status_got.status_byte  = o_status_byte;
            status_got.angle_byte   = o_angle_byte;
            status_got.go_byte      = o_go_byte;
            status_got.turn_byte    = o_turn_byte;
            status_got.position_x   = o_position_x;
            status_got.position_y   = o_position_y;
            status_got.offline      = o_offline;
            status_got.target_valid = o_target_valid;
            if (pending_status.size() == 0) begin
                $display("%0t ns: result item with none expected", $time);
                mismatches++;
            end else begin
                status_want = pending_status.pop_front();
                if (status_got.frame_ok !== status_want.frame_ok)
                    report_mismatch("frame_ok", status_want.frame_ok, status_got.frame_ok);
                if (status_got.checksum_bad !== status_want.checksum_bad)
                    report_mismatch("checksum_bad", status_want.checksum_bad,
                                    status_got.checksum_bad);
                if (status_got.switch_value !== status_want.switch_value)
                    report_mismatch("switch_value", status_want.switch_value,
                                    status_got.switch_value);
                if (status_got.status_byte !== status_want.status_byte)
                    report_mismatch("status_byte", status_want.status_byte,
                                    status_got.status_byte);
                if (status_got.angle_byte !== status_want.angle_byte)
                    report_mismatch("angle_byte", status_want.angle_byte, status_got.angle_byte);
                if (status_got.go_byte !== status_want.go_byte)
                    report_mismatch("go_byte", status_want.go_byte, status_got.go_byte);
                if (status_got.turn_byte !== status_want.turn_byte)
                    report_mismatch("turn_byte", status_want.turn_byte, status_got.turn_byte);
                if (status_got.position_x !== status_want.position_x)
                    report_mismatch("position_x", status_want.position_x, status_got.position_x);
                if (status_got.position_y !== status_want.position_y)
                    report_mismatch("position_y", status_want.position_y, status_got.position_y);
                if (status_got.offline !== status_want.offline)
                    report_mismatch("offline", status_want.offline, status_got.offline);
                if (status_got.target_valid !== status_want.target_valid)
                    report_mismatch("target_valid", status_want.target_valid,
                                    status_got.target_valid);
            end
        end
    end

    // limit after reset is 1000 ms: the fifth full tick goes offline
    task automatic test_default_limit();
        repeat (5) send_item(FUNC_TICK, 8'hFF);
    endtask

    task automatic test_directed_frames();
        send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_TICK, 8'hFF);
        // empty payload: checksum lands in the switch field, rest stale
        send_frame(0, FLAW_NONE, 8'h00);
        send_frame(1, FLAW_SUM, 8'hFF);
        // oversize length equal to the start byte is not a new header
        send_item(FUNC_BYTE, HDR_START);
        send_item(FUNC_BYTE, 8'h01);
        send_item(FUNC_BYTE, HDR_THIRD);
        send_item(FUNC_BYTE, HDR_FOURTH);
        send_item(FUNC_BYTE, HDR_START);
        send_item(FUNC_BYTE, HDR_THIRD);
        send_item(FUNC_BYTE, HDR_START);
        send_item(FUNC_BYTE, 8'h00);
        send_item(FUNC_BYTE, HDR_FOURTH);
    endtask

    task automatic test_limit_extremes();
        set_limit(16'd0);
        send_frame(2, FLAW_NONE, FILL_RANDOM);
        send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_TICK, 8'h01);
        set_limit(16'd1);
        send_frame(12, FLAW_NONE, FILL_RANDOM);
        send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_TICK, 8'h01);
        send_item(FUNC_TICK, 8'h00);
        // timer saturation on the last add, then offline
        set_limit(16'hFFFF);
        send_frame(MAX_LEN - 1, FLAW_NONE, FILL_RANDOM);
        send_item(FUNC_TICK, 8'h01);
        repeat (257) send_item(FUNC_TICK, 8'hFF);
        send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_TICK, 8'h00);
        set_limit(LIMIT_RESET);
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        int unsigned pick;
        tick_mix = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_limit(16'($urandom_range(1, 300)));
                1: set_limit(16'($urandom_range(300, 2000)));
                2: set_limit(16'($urandom_range(1, 600)));
                default: set_limit(16'($urandom_range(1, 65535)));
            endcase
            tx_gaps = (phase != 2);
            rx_gaps = (phase != 2);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    send_frame($urandom_range(0, MAX_LEN - 1), FLAW_NONE, FILL_RANDOM);
                end else if (pick < 70) begin
                    send_frame($urandom_range(0, MAX_LEN - 1),
                               t_frame_flaw'($urandom_range(FLAW_SUM, FLAW_CUT)), FILL_RANDOM);
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 4)) send_item(FUNC_TICK, 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 5)) send_item(FUNC_BYTE, 8'($urandom));
                end
            end
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // long receiver hold while items keep coming back to back
    task automatic test_output_backpressure();
        int unsigned start;
        settle();
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        start = items_sent;
        while (items_sent - start < 40)
            send_frame($urandom_range(0, MAX_LEN - 1), FLAW_NONE, FILL_RANDOM);
        tx_gaps = 1'b1;
    endtask

    initial begin
        reset_receiver();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_limit();
        test_directed_frames();
        test_limit_extremes();
        test_random_traffic();
        test_output_backpressure();
        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
